// ===== sv/sscd_pkg.sv =====
// ----------------------------------------------------------------------------
// sscd_pkg
// Types, constants and the crc-16 byte update for the soil sensor
// frame decoder.
// ----------------------------------------------------------------------------
package sscd_pkg;

	localparam int REGISTER_COUNT = 7;
	localparam int SLOT_W = $clog2(REGISTER_COUNT);

	localparam logic [4:0] FRAME_LENGTH   = 5'd19;
	localparam logic [4:0] LAST_INDEX     = 5'd18;
	localparam logic [4:0] CRC_LOW_INDEX  = 5'd17;
	localparam logic [4:0] CRC_END_INDEX  = 5'd16;
	localparam logic [4:0] REG_FIRST_IDX  = 5'd3;
	localparam logic [4:0] REG_LOW_FIRST  = 5'd4;

	localparam logic [15:0] CRC_PRESET = 16'hFFFF;
	localparam logic [15:0] CRC_POLY   = 16'hA001;

	localparam logic [15:0]        HUMIDITY_MAX = 16'd1000;
	localparam logic signed [15:0] TEMP_MIN     = -16'sd400;
	localparam logic signed [15:0] TEMP_MAX     = 16'sd800;
	localparam logic [15:0]        COND_MAX     = 16'd10000;
	localparam logic [15:0]        PH_MIN       = 16'd30;
	localparam logic [15:0]        PH_MAX       = 16'd100;
	localparam logic [15:0]        NPK_MAX      = 16'd1999;

	typedef struct packed {
		logic [7:0] rx_byte;
		logic       frame_start;
	} in_t;

	typedef struct packed {
		logic [15:0]        humidity_tenths;
		logic signed [15:0] temperature_tenths;
		logic [15:0]        conductivity;
		logic [15:0]        ph_tenths;
		logic [15:0]        nitrogen;
		logic [15:0]        phosphorus;
		logic [15:0]        potassium;
		logic               crc_ok;
		logic               range_ok;
		logic               sample_valid;
	} out_t;

	// reflected crc-16, one byte, eight shift steps
	function automatic logic [15:0] crc_update(input logic [15:0] crc_in,
		input logic [7:0] b);
		logic [15:0] c;
		c = crc_in ^ {8'h00, b};
		for (int k = 0; k < 8; k++) begin
			if (c[0]) begin
				c = (c >> 1) ^ CRC_POLY;
			end else begin
				c = c >> 1;
			end
		end
		return c;
	endfunction

endpackage

// ===== sv/sscd_frame.sv =====
// ----------------------------------------------------------------------------
// sscd_frame
// Frame byte tracking, crc accumulation, register capture and the
// result word formed on the last byte of a frame.
// ----------------------------------------------------------------------------
module sscd_frame (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          advance,
	input  sscd_pkg::in_t item,
	output logic          emit,
	output sscd_pkg::out_t result
);
	import sscd_pkg::*;

	logic [4:0]  byte_index_q;
	logic [15:0] crc_q;
	logic [15:0] store_q [REGISTER_COUNT];
	logic [7:0]  pending_q;

	logic [4:0]        idx;
	logic              open;
	logic [15:0]       crc_base;
	logic [15:0]       crc_next;
	logic [SLOT_W-1:0] slot;
	logic              take_high;
	logic              take_low;
	logic [15:0]       rx_crc;
	logic              crc_ok;
	logic              range_ok;

	always_comb begin
		idx       = item.frame_start ? 5'd0 : byte_index_q;
		open      = item.frame_start || (byte_index_q < FRAME_LENGTH);
		emit      = open && (idx == LAST_INDEX);
		crc_base  = item.frame_start ? CRC_PRESET : crc_q;
		crc_next  = crc_update(crc_base, item.rx_byte);
		slot      = SLOT_W'(idx[4:1] - REG_LOW_FIRST[4:1]);
		take_high = ((idx >= REG_FIRST_IDX) && (idx <= CRC_END_INDEX) && idx[0])
			|| (idx == CRC_LOW_INDEX);
		take_low  = (idx >= REG_LOW_FIRST) && (idx <= CRC_END_INDEX) && !idx[0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			byte_index_q <= FRAME_LENGTH;
			crc_q        <= CRC_PRESET;
			pending_q    <= 8'h00;
			for (int i = 0; i < REGISTER_COUNT; i++) begin
				store_q[i] <= 16'h0000;
			end
		end else if (advance && open) begin
			if (idx <= CRC_END_INDEX) begin
				crc_q <= crc_next;
			end
			if (take_high) begin
				pending_q <= item.rx_byte;
			end
			if (take_low) begin
				store_q[slot] <= {pending_q, item.rx_byte};
			end
			byte_index_q <= emit ? FRAME_LENGTH : idx + 5'd1;
		end
	end

	// received crc comes low byte first
	always_comb begin
		rx_crc   = {item.rx_byte, pending_q};
		crc_ok   = (rx_crc == crc_q);
		range_ok = (store_q[0] <= HUMIDITY_MAX)
			&& ($signed(store_q[1]) >= TEMP_MIN) && ($signed(store_q[1]) <= TEMP_MAX)
			&& (store_q[2] <= COND_MAX)
			&& (store_q[3] >= PH_MIN) && (store_q[3] <= PH_MAX)
			&& (store_q[4] <= NPK_MAX)
			&& (store_q[5] <= NPK_MAX)
			&& (store_q[6] <= NPK_MAX);

		result.humidity_tenths    = store_q[0];
		result.temperature_tenths = $signed(store_q[1]);
		result.conductivity       = store_q[2];
		result.ph_tenths          = store_q[3];
		result.nitrogen           = store_q[4];
		result.phosphorus         = store_q[5];
		result.potassium          = store_q[6];
		result.crc_ok             = crc_ok;
		result.range_ok           = range_ok;
		result.sample_valid       = crc_ok && range_ok;
	end

endmodule

// ===== sv/sscd_outreg.sv =====
// ----------------------------------------------------------------------------
// sscd_outreg
// Result register with valid/stall handshake toward the consumer.
// ----------------------------------------------------------------------------
module sscd_outreg (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           load,
	input  sscd_pkg::out_t load_data,
	output logic           free,
	output logic           res_valid,
	input  logic           res_stall,
	output sscd_pkg::out_t res
);
	import sscd_pkg::*;

	logic valid_q;
	out_t data_q;

	assign free      = !valid_q || !res_stall;
	assign res_valid = valid_q;
	assign res       = data_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (load) begin
			valid_q <= 1'b1;
		end else if (!res_stall) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			data_q <= load_data;
		end
	end

endmodule

// ===== sv/soil_sensor_modbus_frame_decoder_core.sv =====
// data path: a byte is registered in the input stage on acceptance, then
// processed in the frame stage; the result of byte 18 is loaded into the
// result register when that byte advances and is offered from there
// throughput: one byte per cycle; the input stalls only while the last byte
// of a frame waits for a stalled result register
// reset: asynchronous, no frame open, crc at preset, captured registers zero
// ----------------------------------------------------------------------------
// soil_sensor_modbus_frame_decoder_core
// Modbus rtu read response decoder for a seven-register soil sensor.
// ----------------------------------------------------------------------------
module soil_sensor_modbus_frame_decoder_core (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           data_valid,
	output logic           data_stall,
	input  sscd_pkg::in_t  data,
	output logic           res_valid,
	input  logic           res_stall,
	output sscd_pkg::out_t res
);
	import sscd_pkg::*;

	logic valid_s1;
	in_t  data_s1;
	logic emit;
	out_t frame_res;
	logic free;
	logic advance;

	assign advance    = valid_s1 && (!emit || free);
	assign data_stall = valid_s1 && !advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!data_stall) begin
			valid_s1 <= data_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (!data_stall && data_valid) begin
			data_s1 <= data;
		end
	end

	sscd_frame u_frame (
		.clk     (clk),
		.arst_n  (arst_n),
		.advance (advance),
		.item    (data_s1),
		.emit    (emit),
		.result  (frame_res)
	);

	sscd_outreg u_outreg (
		.clk       (clk),
		.arst_n    (arst_n),
		.load      (advance && emit),
		.load_data (frame_res),
		.free      (free),
		.res_valid (res_valid),
		.res_stall (res_stall),
		.res       (res)
	);

endmodule

// ===== sv/sscd_checker.sv =====
// ----------------------------------------------------------------------------
// sscd_checker
// Port-level checks on the decoder input and result channels.
// ----------------------------------------------------------------------------
module sscd_checker (
	input logic           clk,
	input logic           arst_n,
	input logic           data_valid,
	input logic           data_stall,
	input sscd_pkg::in_t  data,
	input logic           res_valid,
	input logic           res_stall,
	input sscd_pkg::out_t res
);
	import sscd_pkg::*;

	a_in_hold: assert property (@(posedge clk) disable iff (!arst_n)
		data_valid && data_stall |=> data_valid && $stable(data))
		else $error("stalled input transaction changed");

	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_stall |=> res_valid && $stable(res))
		else $error("stalled result changed");

	a_sample_flag: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> (res.sample_valid == (res.crc_ok && res.range_ok)))
		else $error("sample_valid does not match crc_ok and range_ok");

	a_range_temp: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res.range_ok |->
			(res.temperature_tenths >= TEMP_MIN) && (res.temperature_tenths <= TEMP_MAX)
			&& (res.ph_tenths >= PH_MIN) && (res.ph_tenths <= PH_MAX))
		else $error("range_ok set with out of range value");

	// the input only backs up behind a held result
	a_in_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		data_stall |-> res_valid && res_stall)
		else $error("input stalled with no held result");

endmodule

bind soil_sensor_modbus_frame_decoder_core sscd_checker u_sscd_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.data_valid (data_valid),
	.data_stall (data_stall),
	.data       (data),
	.res_valid  (res_valid),
	.res_stall  (res_stall),
	.res        (res)
);
